@@ sv/ssso_pkg.sv @@
// ----------------------------------------------------------------------------
// Scanline sine scroll package
// Shared types, codes, constants and arithmetic helpers for the per-scanline
// wave scroll offset generator.
// ----------------------------------------------------------------------------
package ssso_pkg;

    localparam int LINES_DEFAULT       = 160;
    localparam int TABLE_DEPTH_DEFAULT = 256;

    // Line numbers and table indexes travel as 8-bit values.
    localparam int LINE_W  = 8;
    localparam int INDEX_W = 8;

    // Entries in the queue between the front and the back.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_TABLE_WRITE = 2'd0,
        OP_FRAME_START = 2'd1,
        OP_SCANLINE    = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_X_START = 3'd0,
        CFG_FREQ_X        = 3'd1,
        CFG_FREQ_Y        = 3'd2,
        CFG_STEP_X        = 3'd3,
        CFG_STEP_Y        = 3'd4,
        CFG_AMP_X         = 3'd5,
        CFG_AMP_Y         = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        ENT_WRITE = 1'b0,
        ENT_LINE  = 1'b1
    } entry_kind_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [INDEX_W-1:0]  table_index;
        logic signed [15:0]  table_value;
        logic [15:0]         scroll_x;
        logic signed [15:0]  scroll_v;
    } in_item_t;

    typedef struct packed {
        logic                page;
        logic [LINE_W-1:0]   line_number;
        logic [15:0]         offset_x;
        logic [15:0]         offset_y;
    } out_item_t;

    typedef struct packed {
        logic [15:0]         phase_x_start;
        logic signed [31:0]  freq_x;
        logic signed [31:0]  freq_y;
        logic signed [31:0]  step_x;
        logic signed [31:0]  step_y;
        logic signed [31:0]  amp_x;
        logic signed [31:0]  amp_y;
    } cfg_t;

    // Everything a scanline carries besides its two table samples.
    typedef struct packed {
        logic                page;
        logic [LINE_W-1:0]   line_number;
        logic [15:0]         base_h;
        logic [15:0]         base_v;
    } line_tag_t;

    // One queued job: a table write (idx_h, wdata) or a scanline lookup.
    typedef struct packed {
        entry_kind_t         kind;
        logic [INDEX_W-1:0]  idx_h;
        logic [INDEX_W-1:0]  idx_v;
        logic [15:0]         wdata;
        line_tag_t           tag;
    } entry_t;

    typedef struct packed {
        logic                head_valid;
        logic                full;
        logic [QCNT_W-1:0]   count;
    } q_status_t;

    // Remainder of an 8-bit index by the table depth, one conditional
    // subtract per bit position of the quotient.
    function automatic logic [INDEX_W-1:0] mod_depth(input logic [INDEX_W-1:0] v,
                                                     input int unsigned depth);
        logic [15:0] rem;
        logic [15:0] sh;
        rem = {8'd0, v};
        for (int k = INDEX_W - 1; k >= 0; k--) begin
            sh = 16'(depth) << k;
            if (rem >= sh) begin
                rem = rem - sh;
            end
        end
        return rem[INDEX_W-1:0];
    endfunction

    // Product scaled down by 2^16 with a floor shift, then by 256 with
    // truncation toward zero, then added to the base modulo 2^16.
    function automatic logic [15:0] scale_offset(input logic signed [47:0] p,
                                                 input logic [15:0] base);
        logic signed [31:0] q;
        logic signed [31:0] t;
        logic signed [31:0] r;
        q = p[47:16];
        t = q[31] ? (q + 32'sd255) : q;
        r = t >>> 8;
        return r[15:0] + base;
    endfunction

endpackage

@@ sv/ssso_queue.sv @@
// ----------------------------------------------------------------------------
// Job queue
// Small in-order queue of table writes and scanline lookups between the
// front and the back.
// ----------------------------------------------------------------------------
module ssso_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ssso_pkg::entry_t    push_entry,
    input  logic                pop,
    output ssso_pkg::entry_t    head,
    output ssso_pkg::q_status_t status
);

    ssso_pkg::entry_t                 store [ssso_pkg::QDEPTH];
    logic [ssso_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ssso_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ssso_pkg::QCNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    assign head              = store[rd_ptr_reg];
    assign status.head_valid = (count_reg != '0);
    assign status.full       = (count_reg == ssso_pkg::QCNT_W'(ssso_pkg::QDEPTH));
    assign status.count      = count_reg;

endmodule

@@ sv/ssso_front.sv @@
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, keeps the frame state (phase accumulators, bases, page,
// line counter) and turns table writes and live scanlines into queue jobs.
// ----------------------------------------------------------------------------
module ssso_front #(
    parameter int LINES       = ssso_pkg::LINES_DEFAULT,
    parameter int TABLE_DEPTH = ssso_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  ssso_pkg::in_item_t item,
    input  ssso_pkg::cfg_t     cfg,
    input  logic               q_full,
    output logic               push,
    output ssso_pkg::entry_t   entry
);

    logic [31:0]                 acc_h_reg, acc_h_next;
    logic [31:0]                 acc_v_reg, acc_v_next;
    logic [15:0]                 phase_v_reg, phase_v_next;
    logic                        page_reg, page_next;
    logic [ssso_pkg::LINE_W-1:0] line_cnt_reg, line_cnt_next;
    logic [15:0]                 base_h_reg, base_h_next;
    logic [15:0]                 base_v_reg, base_v_next;
    logic                        accept;
    logic [16:0]                 seed_h;
    logic [16:0]                 seed_v;

    assign accept = item_valid && !q_full;
    assign seed_h = {1'b0, cfg.phase_x_start} + {1'b0, item.scroll_v};
    assign seed_v = {1'b0, phase_v_reg} + {1'b0, item.scroll_v};

    always_comb
    begin
        acc_h_next    = acc_h_reg;
        acc_v_next    = acc_v_reg;
        phase_v_next  = phase_v_reg;
        page_next     = page_reg;
        line_cnt_next = line_cnt_reg;
        base_h_next   = base_h_reg;
        base_v_next   = base_v_reg;
        push          = 1'b0;
        entry         = '0;
        entry.kind    = ssso_pkg::ENT_LINE;
        entry.idx_h   = ssso_pkg::mod_depth(acc_h_reg[23:16], TABLE_DEPTH);
        entry.idx_v   = ssso_pkg::mod_depth(acc_v_reg[23:16], TABLE_DEPTH);
        entry.tag.page        = page_reg;
        entry.tag.line_number = line_cnt_reg;
        entry.tag.base_h      = base_h_reg;
        entry.tag.base_v      = base_v_reg;
        if (accept)
        begin
            case (item.op)
                ssso_pkg::OP_TABLE_WRITE:
                begin
                    push        = 1'b1;
                    entry.kind  = ssso_pkg::ENT_WRITE;
                    entry.idx_h = ssso_pkg::mod_depth(item.table_index, TABLE_DEPTH);
                    entry.wdata = item.table_value;
                end
                ssso_pkg::OP_FRAME_START:
                begin
                    base_h_next   = item.scroll_x;
                    base_v_next   = item.scroll_v;
                    acc_h_next    = {15'd0, seed_h} * cfg.freq_x;
                    acc_v_next    = {15'd0, seed_v} * cfg.freq_y;
                    phase_v_next  = phase_v_reg + 16'd1;
                    page_next     = !page_reg;
                    line_cnt_next = '0;
                end
                ssso_pkg::OP_SCANLINE:
                begin
                    if (line_cnt_reg < ssso_pkg::LINE_W'(LINES))
                    begin
                        push          = 1'b1;
                        acc_h_next    = acc_h_reg + cfg.step_x;
                        acc_v_next    = acc_v_reg + cfg.step_y;
                        line_cnt_next = line_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_h_reg    <= '0;
            acc_v_reg    <= '0;
            phase_v_reg  <= '0;
            page_reg     <= 1'b0;
            line_cnt_reg <= ssso_pkg::LINE_W'(LINES);
            base_h_reg   <= '0;
            base_v_reg   <= '0;
        end
        else
        begin
            acc_h_reg    <= acc_h_next;
            acc_v_reg    <= acc_v_next;
            phase_v_reg  <= phase_v_next;
            page_reg     <= page_next;
            line_cnt_reg <= line_cnt_next;
            base_h_reg   <= base_h_next;
            base_v_reg   <= base_v_next;
        end
    end

endmodule

@@ sv/ssso_back.sv @@
// ----------------------------------------------------------------------------
// Wave back end
// Owns the wave table, performs queued writes and runs scanline lookups
// through table read, amplitude multiply and scaling into the result register.
// ----------------------------------------------------------------------------
module ssso_back #(
    parameter int TABLE_DEPTH = ssso_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssso_pkg::entry_t    head,
    input  logic                head_valid,
    input  ssso_pkg::cfg_t      cfg,
    input  logic                result_stall,
    output logic                pop,
    output logic                result_valid,
    output ssso_pkg::out_item_t result
);

    localparam int TW = $clog2(TABLE_DEPTH);

    logic [15:0]             wave_mem [TABLE_DEPTH];

    logic                    adv;
    logic                    take_line;
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic                    result_valid_reg, result_valid_next;
    logic signed [15:0]      s1_sample_h_reg;
    logic signed [15:0]      s1_sample_v_reg;
    ssso_pkg::line_tag_t     s1_tag_reg;
    logic signed [47:0]      s2_prod_h_reg, s2_prod_h_next;
    logic signed [47:0]      s2_prod_v_reg, s2_prod_v_next;
    ssso_pkg::line_tag_t     s2_tag_reg;
    ssso_pkg::out_item_t     result_reg, result_next;

    // The whole pipe moves together whenever the result register can take data.
    assign adv       = !result_valid_reg || !result_stall;
    assign pop       = head_valid && adv;
    assign take_line = pop && (head.kind == ssso_pkg::ENT_LINE);

    always_comb
    begin
        s1_valid_next     = adv ? take_line : s1_valid_reg;
        s2_valid_next     = adv ? s1_valid_reg : s2_valid_reg;
        result_valid_next = adv ? s2_valid_reg : result_valid_reg;
        s2_prod_h_next    = s1_sample_h_reg * cfg.amp_x;
        s2_prod_v_next    = s1_sample_v_reg * cfg.amp_y;
        result_next.page        = s2_tag_reg.page;
        result_next.line_number = s2_tag_reg.line_number;
        result_next.offset_x    = ssso_pkg::scale_offset(s2_prod_h_reg, s2_tag_reg.base_h);
        result_next.offset_y    = ssso_pkg::scale_offset(s2_prod_v_reg, s2_tag_reg.base_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Wave table: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (pop && (head.kind == ssso_pkg::ENT_WRITE))
        begin
            wave_mem[head.idx_h[TW-1:0]] <= head.wdata;
        end
        if (take_line)
        begin
            s1_sample_h_reg <= wave_mem[head.idx_h[TW-1:0]];
            s1_sample_v_reg <= wave_mem[head.idx_v[TW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg    <= head.tag;
            s2_prod_h_reg <= s2_prod_h_next;
            s2_prod_v_reg <= s2_prod_v_next;
            s2_tag_reg    <= s1_tag_reg;
            result_reg    <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ sv/scanline_sine_scroll_offsets.sv @@
// ----------------------------------------------------------------------------
// Scanline sine scroll offsets
// Per-scanline background scroll offsets modulated by a loadable wave table.
// ----------------------------------------------------------------------------
// The block takes one request per clock. A table-write request stores a
// signed 16-bit wave sample, a frame-start request latches the scroll bases,
// seeds both phase accumulators and flips the output page, and each of the
// next LINES scanline requests produces one result with the horizontal and
// vertical offsets for that line; scanline requests beyond LINES, and the
// unused op code, produce nothing. Requests are handled in a front end that
// owns the frame state and a back end that owns the wave table, joined by a
// four-entry queue, so the request side keeps going while a result waits.
// A scanline result reaches the result port through the queue, table read,
// multiply and scale registers, and results then follow one per cycle while
// the result side is not stalled; the sustained rate is one request per
// cycle, set by the single table read and the one multiplier per axis in the
// back end. The request side stalls only while the queue is full, which
// happens only when the result side has been stalled for a while.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and must only be changed while no scanline is in flight.
// ----------------------------------------------------------------------------
module scanline_sine_scroll_offsets #(
    parameter int LINES       = ssso_pkg::LINES_DEFAULT,
    parameter int TABLE_DEPTH = ssso_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  ssso_pkg::in_item_t                 item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output ssso_pkg::out_item_t                result,
    input  logic                               cfg_we,
    input  logic [ssso_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ssso_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ssso_pkg::cfg_t      cfg_reg, cfg_next;
    logic                q_push;
    logic                q_pop;
    ssso_pkg::entry_t    q_push_entry;
    ssso_pkg::entry_t    q_head;
    ssso_pkg::q_status_t q_status;

    // Configuration registers. Writes to an index past the last register
    // are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ssso_pkg::CFG_PHASE_X_START: cfg_next.phase_x_start = cfg_data[15:0];
                ssso_pkg::CFG_FREQ_X:        cfg_next.freq_x        = cfg_data;
                ssso_pkg::CFG_FREQ_Y:        cfg_next.freq_y        = cfg_data;
                ssso_pkg::CFG_STEP_X:        cfg_next.step_x        = cfg_data;
                ssso_pkg::CFG_STEP_Y:        cfg_next.step_y        = cfg_data;
                ssso_pkg::CFG_AMP_X:         cfg_next.amp_x         = cfg_data;
                ssso_pkg::CFG_AMP_Y:         cfg_next.amp_y         = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The request side is held off only by a full queue.
    assign item_stall = q_status.full;

    ssso_front #(
        .LINES       (LINES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_reg),
        .q_full     (q_status.full),
        .push       (q_push),
        .entry      (q_push_entry)
    );

    ssso_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    ssso_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (q_status.head_valid),
        .cfg          (cfg_reg),
        .result_stall (result_stall),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // A job must never be queued into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_status.full)
        else $error("job pushed into a full queue");

    // The back end must not take a job while a result is stuck at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !(result_valid && result_stall))
        else $error("queue popped while the result register is stalled");

    // The fill count never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= ssso_pkg::QCNT_W'(ssso_pkg::QDEPTH))
        else $error("queue fill count out of range");

    // Every delivered result belongs to a line of the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.line_number < ssso_pkg::LINE_W'(LINES)))
        else $error("result carries a line number past the frame");

endmodule
